// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the weight map generator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define GWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay between cause and effect.
`define GWM_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
		else $error(msg);

`endif

// ===== rtl/gwm_pkg.sv =====
// Types, constants and the exponential table of the Gaussian weight map generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package gwm_pkg;

	localparam int MAP_SIZE = 256;
	localparam int EXP_TABLE_DEPTH = 256;

	localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int DEPTH_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IDXP_W = 24 + DEPTH_W;
	localparam int EXP_ENTRY_W = 17;
	localparam int GWM_LATENCY = 9;

	localparam logic [24:0] LOG2E_Q24 = 25'h1715476;
	localparam logic [63:0] LN2_Q30 = 64'h2C5C85FE;
	localparam logic [23:0] WEIGHT_MAX = 24'hFFFFFF;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_COEF_XX  = 3'd2,
		REG_COEF_XY  = 3'd3,
		REG_COEF_YY  = 3'd4,
		REG_OUT_GAIN = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pixel_row;
		logic [7:0] pixel_col;
	} in_item_t;

	typedef struct packed {
		logic [23:0] weight;
		logic        saturated;
	} out_item_t;

	typedef struct packed {
		logic [15:0]        center_x;
		logic [15:0]        center_y;
		logic signed [24:0] coef_xx;
		logic signed [24:0] coef_xy;
		logic signed [24:0] coef_yy;
		logic [23:0]        out_gain;
	} gwm_cfg_t;

	// Travels with the data down the pipeline; the gain stage keeps only its valid bit.
	typedef struct packed {
		logic valid;
		logic oob;
	} gwm_tag_t;

	typedef logic [EXP_ENTRY_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

	// Entry i holds 2^-(i/EXP_TABLE_DEPTH) in Q.16, from a 15-term series in Q.30.
	function automatic exp_table_t build_exp_table();
		exp_table_t  tbl;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			y = (64'(i) * LN2_Q30) / 64'(EXP_TABLE_DEPTH);
			term = 64'd1 << 30;
			pos = term;
			neg = '0;
			for (int k = 1; k <= 14; k++) begin
				term = ((term * y) >> 30) / 64'(k);
				if (k[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
			tbl[i] = EXP_ENTRY_W'(((pos - neg) + (64'd1 << 13)) >> 14);
		end
		return tbl;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

// ===== rtl/gwm_quad.sv =====
// Stages one to five: center offsets, squares, coefficient products and the clamped form.
// Depends on gwm_pkg.
`default_nettype none

module gwm_quad
	import gwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire in_item_t    in_item,
	input  wire gwm_cfg_t    cfg,
	output gwm_tag_t         tag_s5,
	output logic [23:0]      q16_s5
);

	gwm_tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [17:0] dx_s1, dy_s1;
	logic signed [35:0] sq_s2 [3];
	logic signed [42:0] pl_s3 [3];
	logic signed [43:0] ph_s3 [3];
	logic signed [63:0] term_s4 [3];
	logic signed [24:0] coef [3];
	logic signed [63:0] q_sum;
	logic               oob;

	assign oob = (32'(in_item.pixel_row) >= 32'(MAP_SIZE)) ||
		(32'(in_item.pixel_col) >= 32'(MAP_SIZE));

	assign coef[0] = cfg.coef_xx;
	assign coef[1] = cfg.coef_xy;
	assign coef[2] = cfg.coef_yy;

	assign q_sum = term_s4[0] + term_s4[1] + term_s4[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= '{valid: in_valid, oob: oob};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({2'b00, cfg.center_x}) - $signed({2'b00, in_item.pixel_col, 8'h00});
		dy_s1 <= $signed({2'b00, cfg.center_y}) - $signed({2'b00, in_item.pixel_row, 8'h00});
		sq_s2[0] <= dx_s1 * dx_s1;
		sq_s2[1] <= dx_s1 * dy_s1;
		sq_s2[2] <= dy_s1 * dy_s1;
		for (int i = 0; i < 3; i++) begin
			pl_s3[i] <= coef[i] * $signed({1'b0, sq_s2[i][16:0]});
			ph_s3[i] <= coef[i] * $signed(sq_s2[i][35:17]);
			term_s4[i] <= (64'(ph_s3[i]) <<< 17) + 64'(pl_s3[i]);
		end
		if (q_sum <= 64'sd0) begin
			q16_s5 <= '0;
		end else if (|q_sum[63:44]) begin
			q16_s5 <= WEIGHT_MAX;
		end else begin
			q16_s5 <= q_sum[43:20];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gwm_exp.sv =====
// Stages six to eight: base-two exponent, table index and the shifted table entry.
// Depends on gwm_pkg.
`default_nettype none

module gwm_exp
	import gwm_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire gwm_tag_t                tag_s5,
	input  wire logic [23:0]             q16_s5,
	output gwm_tag_t                     tag_s8,
	output logic [EXP_ENTRY_W-1:0]       e_s8
);

	gwm_tag_t tag_s6, tag_s7;

	logic [48:0]          t_prod;
	logic [32:0]          t_s6;
	logic [IDXP_W-1:0]    idx_prod;
	logic [8:0]           n_s7;
	logic [EXP_IDX_W-1:0] idx_s7;

	assign t_prod = 49'(q16_s5) * 49'(LOG2E_Q24);
	assign idx_prod = IDXP_W'(t_s6[23:0]) * IDXP_W'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
		end else begin
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
		end
	end

	always_ff @(posedge clk) begin
		t_s6 <= t_prod[48:16];
		n_s7 <= t_s6[32:24];
		idx_s7 <= idx_prod[24 +: EXP_IDX_W];
		e_s8 <= EXP_TABLE[idx_s7] >> n_s7;
	end

endmodule

`default_nettype wire

// ===== rtl/gwm_scale.sv =====
// Stage nine: gain, rounding, saturation and the result register.
// Depends on gwm_pkg.
`default_nettype none

module gwm_scale
	import gwm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire gwm_tag_t               tag_s8,
	input  wire logic [EXP_ENTRY_W-1:0] e_s8,
	input  wire logic [23:0]            out_gain,
	output logic                        valid_s9,
	output out_item_t                   result_s9
);

	logic [40:0] prod;
	logic [24:0] w;

	assign prod = 41'(e_s8) * 41'(out_gain) + 41'd32768;
	assign w = prod[40:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= tag_s8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s8.oob) begin
			result_s9 <= '{weight: '0, saturated: 1'b0};
		end else if (w[24]) begin
			result_s9 <= '{weight: WEIGHT_MAX, saturated: 1'b1};
		end else begin
			result_s9 <= '{weight: w[23:0], saturated: 1'b0};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gaussian_weight_map_generator_core.sv =====
// Top level of the Gaussian weight map generator: register file and the nine-stage pipeline.
// Depends on gwm_pkg, gwm_quad, gwm_exp and gwm_scale.
//
// The block takes one pixel coordinate per clock whenever start is high and busy is low;
// busy is high only while reset is applied. Each pixel yields one weight, shown on result for
// a single cycle with result_valid high, after it has passed the nine register stages:
// offsets, squares, split coefficient products, partial sums, the clamped form, the log2(e)
// product, the table index, the table lookup with its shift, and the gain. The receiver
// cannot stall, so results must be taken as they appear. Registers are written through the
// cfg channel and must only change while no pixel is in flight.
`default_nettype none

module gaussian_weight_map_generator_core
	import gwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    pixel,
	output logic             result_valid,
	output out_item_t        result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [24:0] cfg_data
);

	gwm_cfg_t                 cfg_q;
	gwm_tag_t                 tag_s5, tag_s8;
	logic [23:0]              q16_s5;
	logic [EXP_ENTRY_W-1:0]   e_s8;

	assign busy = ~arst_n;
	assign cfg_ready = arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{center_x: '0, center_y: '0, coef_xx: '0, coef_xy: '0,
				coef_yy: '0, out_gain: 24'd65536};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: cfg_q.center_x <= cfg_data[15:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_data[15:0];
				REG_COEF_XX:  cfg_q.coef_xx <= $signed(cfg_data);
				REG_COEF_XY:  cfg_q.coef_xy <= $signed(cfg_data);
				REG_COEF_YY:  cfg_q.coef_yy <= $signed(cfg_data);
				REG_OUT_GAIN: cfg_q.out_gain <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	gwm_quad u_quad (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_item  (pixel),
		.cfg      (cfg_q),
		.tag_s5   (tag_s5),
		.q16_s5   (q16_s5)
	);

	gwm_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s5 (tag_s5),
		.q16_s5 (q16_s5),
		.tag_s8 (tag_s8),
		.e_s8   (e_s8)
	);

	gwm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s8    (tag_s8),
		.e_s8      (e_s8),
		.out_gain  (cfg_q.out_gain),
		.valid_s9  (result_valid),
		.result_s9 (result)
	);

endmodule

`default_nettype wire

// ===== rtl/gwm_checker.sv =====
// Port-level checks of the Gaussian weight map generator, bound to its top level.
// Depends on gwm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gwm_checker
	import gwm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      result_valid,
	input wire out_item_t result
);

	logic accept;

	assign accept = start && !busy;

	// Every accepted pixel gives a result after the fixed latency.
	`GWM_ASSERT_DLY(a_latency_fwd, clk, arst_n, accept, GWM_LATENCY, result_valid, "result missing after transfer")

	// No result appears without a transfer the fixed latency earlier.
	`GWM_ASSERT_IMP(a_latency_bwd, clk, arst_n, result_valid, $past(accept, GWM_LATENCY), "result without a transfer")

	// A clipped weight must read as the largest code.
	`GWM_ASSERT_IMP(a_sat_max, clk, arst_n, result_valid && result.saturated, result.weight == WEIGHT_MAX, "saturated weight not at maximum")

endmodule

bind gaussian_weight_map_generator_core gwm_checker u_gwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
